// ----- rtl/rgbblur_pkg.sv -----
// shared types, constants and pixel functions of the rgb555 expand and 3x3 blur block
`default_nettype none

package rgbblur_pkg;

    localparam int PIX_W       = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;
    localparam int FW_W        = 12;
    localparam int HGT_W       = 12;
    localparam int BRD_W       = 10;
    localparam int ROW_W       = 11;
    localparam int MAX_HEIGHT  = 2048;
    localparam int OFIFO_DEPTH = 4;
    localparam int OFIFO_PTR_W = 2;
    localparam int OFIFO_CNT_W = 3;

    localparam logic [PIX_W-1:0] NBR_MASK  = 24'hf8f8f8;
    localparam logic [PIX_W-1:0] HALF_MASK = 24'hfefefe;

    localparam logic [FW_W-1:0]  RST_FRAME_WIDTH  = 12'd640;
    localparam logic [HGT_W-1:0] RST_FRAME_HEIGHT = 12'd480;
    localparam logic [BRD_W-1:0] RST_BORDER_ROWS  = 10'd70;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BORDER_ROWS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUR_ENABLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_FORMAT = 3'd4;

    // input format codes
    localparam logic FMT_RGB888 = 1'b0;
    localparam logic FMT_RGB555 = 1'b1;

    typedef struct packed {
        logic [FW_W-1:0]  frame_width;
        logic [HGT_W-1:0] frame_height;
        logic [BRD_W-1:0] border_rows;
        logic             blur_enable;
        logic             input_format;
    } t_cfg;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
        logic             flush;
    } t_in_beat;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_last;
    } t_out_beat;

    // control of the item sitting in the line buffer read stage
    typedef struct packed {
        logic pixel;
        logic flush;
        logic emit;
        logic blur;
        logic last;
        logic fwd_hit;
        logic sel_above;
    } t_s1_ctl;

    typedef logic [8:0][PIX_W-1:0] t_window;

    function automatic logic [7:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [PIX_W-1:0] to_rgb(input logic [PIX_W-1:0] raw,
                                                 input logic fmt);
        logic [PIX_W-1:0] res;
        if (fmt == FMT_RGB555) begin
            res = {widen5(raw[4:0]), widen5(raw[9:5]), widen5(raw[14:10])};
        end else begin
            res = raw;
        end
        return res;
    endfunction

    // half the centre plus half the sum of the eight masked neighbours, each divided by eight
    function automatic logic [PIX_W-1:0] blur_mix(input t_window win);
        logic [PIX_W-1:0] sum;
        logic [PIX_W-1:0] half_c;
        logic [PIX_W-1:0] half_s;
        sum = '0;
        for (int k = 0; k < 9; k++) begin
            if (k != 4) begin
                sum = sum + ((win[k] & NBR_MASK) >> 3);
            end
        end
        half_c = (win[4] & HALF_MASK) >> 1;
        half_s = (sum & HALF_MASK) >> 1;
        return half_c + half_s;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rgb555_expand_and_3x3_blur.sv -----
// top level of the rgb555 expand and center weighted 3x3 blur block
// usage:
// - input channel carries one pixel beat per raster position, or a flush beat
// - each pixel is taken as packed rgb888 or widened from 5:5:5, per input_format
// - results lag the pixel stream by one row plus one pixel; after the last pixel
//   of a frame the source sends width+1 flush beats to drain the owed results,
//   and frame_last marks the final one
// - a flush beat with nothing owed is taken and dropped
// - one beat is taken per clock while input stall is low; the rate is set by the two line
//   buffers, each with one write and one read port used once per pixel
// - a result passes the read stage and the select stage, then leaves through the output queue
// - when the receiver stalls, results collect in a four entry output queue and
//   input stall rises once the queue entries plus the two stages in flight reach four
// - synchronous reset restores the register defaults (640x480, border 70, blur
//   on, 5:5:5 input), clears counters, window and queue; line buffer contents
//   stay undefined until a frame writes them, so no clearing pass is needed
// - configuration is to be written only while no beat is in flight; the block does not check
`default_nettype none

module rgb555_expand_and_3x3_blur #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic [rgbblur_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [rgbblur_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                                   i_in_valid,
    output      logic                                   o_in_stall,
    input  wire rgbblur_pkg::t_in_beat                  i_in_data,
    output      logic                                   o_out_valid,
    input  wire logic                                   i_out_stall,
    output      rgbblur_pkg::t_out_beat                 o_out_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int NW = rgbblur_pkg::OFIFO_CNT_W;

    rgbblur_pkg::t_cfg             r_cfg;
    logic                          accept;

    logic [CW-1:0]                 above_raddr;
    logic [CW-1:0]                 middle_raddr;
    logic [rgbblur_pkg::PIX_W-1:0] above_rd;
    logic [rgbblur_pkg::PIX_W-1:0] middle_rd;

    rgbblur_pkg::t_s1_ctl          s1;
    logic [rgbblur_pkg::PIX_W-1:0] s1_px;
    logic [CW-1:0]                 s1_col;
    logic [rgbblur_pkg::PIX_W-1:0] s1_fwd;

    logic                          s2_valid;
    rgbblur_pkg::t_out_beat        s2_beat;
    logic [NW-1:0]                 q_count;
    logic [NW-1:0]                 in_flight;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width  <= rgbblur_pkg::RST_FRAME_WIDTH;
            r_cfg.frame_height <= rgbblur_pkg::RST_FRAME_HEIGHT;
            r_cfg.border_rows  <= rgbblur_pkg::RST_BORDER_ROWS;
            r_cfg.blur_enable  <= 1'b1;
            r_cfg.input_format <= rgbblur_pkg::FMT_RGB555;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rgbblur_pkg::CFG_FRAME_WIDTH: begin
                    r_cfg.frame_width <= i_cfg_data;
                end
                rgbblur_pkg::CFG_FRAME_HEIGHT: begin
                    r_cfg.frame_height <= i_cfg_data;
                end
                rgbblur_pkg::CFG_BORDER_ROWS: begin
                    r_cfg.border_rows <= i_cfg_data[rgbblur_pkg::BRD_W-1:0];
                end
                rgbblur_pkg::CFG_BLUR_ENABLE: begin
                    r_cfg.blur_enable <= i_cfg_data[0];
                end
                rgbblur_pkg::CFG_INPUT_FORMAT: begin
                    r_cfg.input_format <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // credit check: queue entries plus both pipeline stages must fit the queue
    assign in_flight  = q_count + NW'(s1.pixel | s1.flush) + NW'(s2_valid);
    assign o_in_stall = in_flight >= NW'(rgbblur_pkg::OFIFO_DEPTH);
    assign accept     = i_in_valid && !o_in_stall;

    // position tracking, flush drain and line buffer addresses
    rgbblur_seq #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_accept       (accept),
        .i_beat         (i_in_data),
        .i_middle_rd    (middle_rd),
        .o_above_raddr  (above_raddr),
        .o_middle_raddr (middle_raddr),
        .o_s1           (s1),
        .o_s1_px        (s1_px),
        .o_s1_col       (s1_col),
        .o_s1_fwd       (s1_fwd)
    );

    // row two above: gets what the middle row held at this column
    rgbblur_ram #(
        .WIDTH (rgbblur_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_above_ram (
        .i_clk   (i_clk),
        .i_we    (s1.pixel),
        .i_waddr (s1_col),
        .i_wdata (middle_rd),
        .i_raddr (above_raddr),
        .o_rdata (above_rd)
    );

    // row just above: gets the incoming pixel
    rgbblur_ram #(
        .WIDTH (rgbblur_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_middle_ram (
        .i_clk   (i_clk),
        .i_we    (s1.pixel),
        .i_waddr (s1_col),
        .i_wdata (s1_px),
        .i_raddr (middle_raddr),
        .o_rdata (middle_rd)
    );

    // window shift, then blur or pass-through select
    rgbblur_win u_win (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1        (s1),
        .i_s1_px     (s1_px),
        .i_s1_fwd    (s1_fwd),
        .i_above_rd  (above_rd),
        .i_middle_rd (middle_rd),
        .o_valid     (s2_valid),
        .o_beat      (s2_beat)
    );

    // output queue toward the receiver
    rgbblur_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s2_valid),
        .i_beat  (s2_beat),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_beat  (o_out_data),
        .o_count (q_count)
    );

endmodule

`default_nettype wire

// ----- rtl/rgbblur_ram.sv -----
// generic simple dual port ram with registered read
`default_nettype none

module rgbblur_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/rgbblur_seq.sv -----
// raster position counters, flush bookkeeping, line buffer addressing and first stage
`default_nettype none

module rgbblur_seq #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire rgbblur_pkg::t_cfg                 i_cfg,
    input  wire logic                              i_accept,
    input  wire rgbblur_pkg::t_in_beat             i_beat,
    input  wire logic [rgbblur_pkg::PIX_W-1:0]     i_middle_rd,
    output      logic [$clog2(MAX_WIDTH)-1:0]      o_above_raddr,
    output      logic [$clog2(MAX_WIDTH)-1:0]      o_middle_raddr,
    output      rgbblur_pkg::t_s1_ctl              o_s1,
    output      logic [rgbblur_pkg::PIX_W-1:0]     o_s1_px,
    output      logic [$clog2(MAX_WIDTH)-1:0]      o_s1_col,
    output      logic [rgbblur_pkg::PIX_W-1:0]     o_s1_fwd
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 2);
    localparam int EW = (WW > rgbblur_pkg::FW_W) ? WW : rgbblur_pkg::FW_W;
    localparam int HW = rgbblur_pkg::HGT_W;
    localparam int RW = rgbblur_pkg::ROW_W;
    localparam int SW = HW + 1;

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [WW-1:0] r_pend, n_pend;

    rgbblur_pkg::t_s1_ctl          r_s1, n_s1;
    logic [rgbblur_pkg::PIX_W-1:0] r_s1_px, n_s1_px;
    logic [CW-1:0]                 r_s1_col, n_s1_col;
    logic [rgbblur_pkg::PIX_W-1:0] r_s1_fwd, n_s1_fwd;

    logic [EW-1:0]          fw_e;
    logic [WW-1:0]          w;
    logic [WW-1:0]          wp1;
    logic [HW-1:0]          h;
    logic [rgbblur_pkg::BRD_W-1:0] b;
    logic                   wrap0;
    logic [CW-1:0]          c;
    logic [HW-1:0]          rowp;
    logic [RW-1:0]          r;
    logic [RW-1:0]          orow;
    logic [WW-1:0]          c1;
    logic                   endrow;
    logic [HW-1:0]          r1;
    logic                   endframe;
    logic [WW-1:0]          idx;
    logic                   sel_above;
    logic [CW-1:0]          above_fl;
    logic [CW-1:0]          middle_fl;
    logic                   flush_live;
    logic                   emit;
    logic                   blur;

    always_comb begin
        // effective frame limits
        fw_e = EW'(i_cfg.frame_width);
        if (fw_e < EW'(3)) begin
            fw_e = EW'(3);
        end else if (fw_e > EW'(MAX_WIDTH)) begin
            fw_e = EW'(MAX_WIDTH);
        end
        w   = WW'(fw_e);
        wp1 = w + WW'(1);

        h = i_cfg.frame_height;
        if (h < HW'(3)) begin
            h = HW'(3);
        end else if (h > HW'(rgbblur_pkg::MAX_HEIGHT)) begin
            h = HW'(rgbblur_pkg::MAX_HEIGHT);
        end
        b = (i_cfg.border_rows == '0) ? rgbblur_pkg::BRD_W'(1) : i_cfg.border_rows;

        // position of this pixel, wrapping a count left beyond a new limit
        wrap0 = WW'(r_col) >= w;
        c     = wrap0 ? '0 : r_col;
        rowp  = HW'(r_row) + (wrap0 ? HW'(1) : HW'(0));
        r     = (rowp >= h) ? '0 : rowp[RW-1:0];
        orow  = r - RW'(1);

        c1       = WW'(c) + WW'(1);
        endrow   = c1 >= w;
        r1       = HW'(r) + HW'(1);
        endframe = endrow && (r1 >= h);

        if (c == '0) begin
            emit = r >= RW'(2);
        end else begin
            emit = r != '0;
        end
        blur = i_cfg.blur_enable && (c >= CW'(2)) && (r != '0)
            && (orow >= RW'(b)) && ((SW'(orow) + SW'(b)) < SW'(h));

        // flush reads the owed results back out of the line buffers
        idx        = (r_pend > wp1) ? '0 : (wp1 - r_pend);
        sel_above  = idx == '0;
        above_fl   = CW'(w - WW'(1));
        middle_fl  = CW'(idx - WW'(1));
        flush_live = i_beat.flush && (r_pend != '0);

        o_above_raddr  = i_beat.flush ? above_fl : c;
        o_middle_raddr = i_beat.flush ? middle_fl : c;

        n_col    = r_col;
        n_row    = r_row;
        n_pend   = r_pend;
        n_s1     = '0;
        n_s1_px  = to_rgb_px();
        n_s1_col = c;
        // the pixel in the read stage writes its buffers at this edge
        n_s1_fwd = sel_above ? i_middle_rd : r_s1_px;

        if (i_accept && !i_beat.flush) begin
            n_col        = endrow ? '0 : c1[CW-1:0];
            n_row        = endrow ? (endframe ? '0 : r1[RW-1:0]) : r;
            n_pend       = endframe ? wp1 : '0;
            n_s1.pixel   = 1'b1;
            n_s1.emit    = emit;
            n_s1.blur    = blur && emit;
        end else if (i_accept && flush_live) begin
            n_pend         = r_pend - WW'(1);
            n_s1.flush     = 1'b1;
            n_s1.emit      = 1'b1;
            n_s1.last      = r_pend == WW'(1);
            n_s1.sel_above = sel_above;
            n_s1.fwd_hit   = r_s1.pixel
                && (r_s1_col == (sel_above ? above_fl : middle_fl));
        end
    end

    function automatic logic [rgbblur_pkg::PIX_W-1:0] to_rgb_px();
        return rgbblur_pkg::to_rgb(i_beat.pixel_in, i_cfg.input_format);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_pend <= '0;
            r_s1   <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_pend <= n_pend;
            r_s1   <= n_s1;
        end
        r_s1_px  <= n_s1_px;
        r_s1_col <= n_s1_col;
        r_s1_fwd <= n_s1_fwd;
    end

    assign o_s1     = r_s1;
    assign o_s1_px  = r_s1_px;
    assign o_s1_col = r_s1_col;
    assign o_s1_fwd = r_s1_fwd;

endmodule

`default_nettype wire

// ----- rtl/rgbblur_win.sv -----
// 3x3 window registers, result select stage and blur arithmetic
`default_nettype none

module rgbblur_win (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rgbblur_pkg::t_s1_ctl          i_s1,
    input  wire logic [rgbblur_pkg::PIX_W-1:0] i_s1_px,
    input  wire logic [rgbblur_pkg::PIX_W-1:0] i_s1_fwd,
    input  wire logic [rgbblur_pkg::PIX_W-1:0] i_above_rd,
    input  wire logic [rgbblur_pkg::PIX_W-1:0] i_middle_rd,
    output      logic                          o_valid,
    output      rgbblur_pkg::t_out_beat        o_beat
);

    rgbblur_pkg::t_window          r_win, n_win;
    logic                          r_s2_v;
    logic                          r_s2_blur;
    logic                          r_s2_flush;
    logic                          r_s2_last;
    logic [rgbblur_pkg::PIX_W-1:0] r_s2_val, n_s2_val;

    always_comb begin
        n_win = r_win;
        if (i_s1.pixel) begin
            n_win[0] = r_win[1];
            n_win[1] = r_win[2];
            n_win[2] = i_above_rd;
            n_win[3] = r_win[4];
            n_win[4] = r_win[5];
            n_win[5] = i_middle_rd;
            n_win[6] = r_win[7];
            n_win[7] = r_win[8];
            n_win[8] = i_s1_px;
        end
        if (i_s1.fwd_hit) begin
            n_s2_val = i_s1_fwd;
        end else begin
            n_s2_val = i_s1.sel_above ? i_above_rd : i_middle_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win      <= '0;
            r_s2_v     <= 1'b0;
            r_s2_blur  <= 1'b0;
            r_s2_flush <= 1'b0;
            r_s2_last  <= 1'b0;
        end else begin
            r_win      <= n_win;
            r_s2_v     <= i_s1.emit;
            r_s2_blur  <= i_s1.blur;
            r_s2_flush <= i_s1.flush;
            r_s2_last  <= i_s1.last;
        end
        r_s2_val <= n_s2_val;
    end

    // window centre is also the pass-through pixel, even at column zero
    always_comb begin
        if (r_s2_blur) begin
            o_beat.pixel_out = rgbblur_pkg::blur_mix(r_win);
        end else if (r_s2_flush) begin
            o_beat.pixel_out = r_s2_val;
        end else begin
            o_beat.pixel_out = r_win[4];
        end
        o_beat.frame_last = r_s2_last;
    end

    assign o_valid = r_s2_v;

endmodule

`default_nettype wire

// ----- rtl/rgbblur_ofifo.sv -----
// small output queue that absorbs results while the receiver stalls
`default_nettype none

module rgbblur_ofifo (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_push,
    input  wire rgbblur_pkg::t_out_beat              i_beat,
    input  wire logic                                i_stall,
    output      logic                                o_valid,
    output      rgbblur_pkg::t_out_beat              o_beat,
    output      logic [rgbblur_pkg::OFIFO_CNT_W-1:0] o_count
);

    localparam int PW = rgbblur_pkg::OFIFO_PTR_W;
    localparam int NW = rgbblur_pkg::OFIFO_CNT_W;

    rgbblur_pkg::t_out_beat r_mem [rgbblur_pkg::OFIFO_DEPTH];
    logic [PW-1:0]          r_wptr;
    logic [PW-1:0]          r_rptr;
    logic [NW-1:0]          r_count;
    logic                   pop;

    assign pop = (r_count != '0) && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + PW'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + PW'(1);
            end
            r_count <= r_count + (i_push ? NW'(1) : NW'(0)) - (pop ? NW'(1) : NW'(0));
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_beat;
        end
    end

    assign o_valid = r_count != '0;
    assign o_beat  = r_mem[r_rptr];
    assign o_count = r_count;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// self-checking testbench for the rgb555 expand and 3x3 blur block
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rgbblur_pkg::*;

    localparam int          MAX_W         = 2048;
    localparam int          SETTLE_CYCLES = 10;      // drain time for beats that make no result
    localparam int          TAIL_CYCLES   = 20;
    localparam int          RANDOM_ITEMS  = 1950;
    localparam int unsigned CYCLE_LIMIT   = 3_000_000;

    // idling mixes used across the run
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_e;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_beat              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_beat             o_out_data;

    rgb555_expand_and_3x3_blur #(
        .MAX_WIDTH (MAX_W)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // percent chance per cycle that the source idles or the sink stalls
    int send_idle_pct = 0;
    int stall_pct     = 0;

    int unsigned mismatch_cnt = 0;
    int unsigned results_seen = 0;

    // shadow copy of the configuration registers
    int unsigned cfg_width;
    int unsigned cfg_height;
    int unsigned cfg_border;
    logic        cfg_blur;
    logic        cfg_format;

    // shadow copy of the line buffers, window and raster position
    logic [PIX_W-1:0] above_line [MAX_W];
    logic [PIX_W-1:0] mid_line   [MAX_W];
    logic [PIX_W-1:0] win        [9];
    int unsigned      col_pos;
    int unsigned      row_pos;
    int unsigned      flush_owed;   // results the finished frame still owes

    // result pixels still to come out, oldest first
    t_out_beat pixels_due [$];

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: a hang anywhere ends the run here
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // sink side backpressure, redrawn every falling edge
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input logic [PIX_W-1:0] got,
                                   input logic [PIX_W-1:0] want);
        $display("mismatch on result %0d, %s: got %06h want %06h",
                 results_seen, what, got, want);
        mismatch_cnt++;
    endtask

    // every beat leaving the block is matched against the oldest predicted pixel
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pixels_due.size() == 0) begin
                report_mismatch("beat with nothing expected", o_out_data.pixel_out, '0);
            end else begin
                want = pixels_due.pop_front();
                if (o_out_data.pixel_out !== want.pixel_out) begin
                    report_mismatch("pixel_out", o_out_data.pixel_out, want.pixel_out);
                end
                if (o_out_data.frame_last !== want.frame_last) begin
                    report_mismatch("frame_last", PIX_W'(o_out_data.frame_last),
                                    PIX_W'(want.frame_last));
                end
            end
            results_seen++;
        end
    end

    // ---------------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------------

    function automatic int unsigned eff_width();
        int unsigned w;
        w = cfg_width;
        if (w < 3) w = 3;
        if (w > MAX_W) w = MAX_W;
        return w;
    endfunction

    function automatic int unsigned eff_height();
        int unsigned h;
        h = cfg_height;
        if (h < 3) h = 3;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return h;
    endfunction

    // 5:5:5 to 8:8:8, each channel's top bits repeated below it;
    // bits 14..10 land in the low byte, bits 4..0 in the high byte
    function automatic logic [PIX_W-1:0] widen_555(input logic [PIX_W-1:0] raw);
        logic [7:0] lo_ch;
        logic [7:0] mid_ch;
        logic [7:0] hi_ch;
        lo_ch  = {raw[14:10], raw[14:12]};
        mid_ch = {raw[9:5], raw[9:7]};
        hi_ch  = {raw[4:0], raw[4:2]};
        return {hi_ch, mid_ch, lo_ch};
    endfunction

    // half the center plus half the sum of the masked neighbours, each
    // divided by eight; masks keep each channel's carries out of the channel above
    function automatic logic [PIX_W-1:0] blurred_center();
        logic [PIX_W-1:0] nsum;
        nsum = '0;
        for (int k = 0; k < 9; k++) begin
            if (k != 4) nsum = nsum + ((win[k] & NBR_MASK) >> 3);
        end
        return ((win[4] & HALF_MASK) >> 1) + ((nsum & HALF_MASK) >> 1);
    endfunction

    // advance the shadow pipeline by one accepted beat and queue its result
    task automatic track_blur_pipeline(input t_in_beat b);
        int unsigned      w;
        int unsigned      h;
        int unsigned      bord;
        int unsigned      pos;
        int unsigned      r;
        int unsigned      c;
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] prev_mid;
        logic [PIX_W-1:0] above_px;
        logic [PIX_W-1:0] mid_px;
        t_out_beat        due;
        w    = eff_width();
        h    = eff_height();
        bord = (cfg_border == 0) ? 1 : cfg_border;
        if (b.flush) begin
            // a flush only matters while the last frame still owes pixels
            if (flush_owed != 0) begin
                pos = (flush_owed > w + 1) ? 0 : w + 1 - flush_owed;
                due.pixel_out = (pos == 0) ? above_line[w-1] : mid_line[pos-1];
                flush_owed--;
                due.frame_last = (flush_owed == 0);
                pixels_due.push_back(due);
            end
        end else begin
            // a pixel drops whatever the last frame still owed
            flush_owed = 0;
            px = (cfg_format == FMT_RGB555) ? widen_555(b.pixel_in) : b.pixel_in;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
            end
            if (row_pos >= h) row_pos = 0;
            r = row_pos;
            c = col_pos;
            prev_mid = win[5];
            above_px = above_line[c];
            mid_px   = mid_line[c];
            win[0] = win[1]; win[1] = win[2]; win[2] = above_px;
            win[3] = win[4]; win[4] = win[5]; win[5] = mid_px;
            win[6] = win[7]; win[7] = win[8]; win[8] = px;
            above_line[c] = mid_px;
            mid_line[c]   = px;
            due.frame_last = 1'b0;
            if (c == 0) begin
                // column 0 releases the last pixel of the row two above
                if (r >= 2) begin
                    due.pixel_out = prev_mid;
                    pixels_due.push_back(due);
                end
            end else if (r >= 1) begin
                if (cfg_blur && c >= 2 && r - 1 >= bord && r - 1 + bord < h) begin
                    due.pixel_out = blurred_center();
                end else begin
                    due.pixel_out = win[4];
                end
                pixels_due.push_back(due);
            end
            col_pos++;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= h) begin
                    row_pos    = 0;
                    flush_owed = w + 1;
                end
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // stimulus helpers; all of them start and end at a falling edge
    // ---------------------------------------------------------------------

    task automatic set_idling(input idle_mode_e mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct = 81;
                stall_pct     = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct = 0;
                stall_pct     = 81;
            end
            default: begin
                send_idle_pct = 19;
                stall_pct     = 19;
            end
        endcase
    endtask

    // one input beat; valid stays up after acceptance so back to back beats
    // never see it drop
    task automatic send_beat(input t_in_beat b);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        track_blur_pipeline(b);
        @(negedge i_clk);
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] value);
        t_in_beat b;
        b.pixel_in = value;
        b.flush    = 1'b0;
        send_beat(b);
    endtask

    // flush beats carry junk in the pixel field, which must be ignored
    task automatic send_flush(input int unsigned n);
        t_in_beat b;
        for (int unsigned k = 0; k < n; k++) begin
            b.pixel_in = PIX_W'($urandom());
            b.flush    = 1'b1;
            send_beat(b);
        end
    endtask

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom());
        endcase
    endfunction

    // random pixels until the raster wraps to a new frame
    task automatic send_frame(input bit with_noise);
        do begin
            send_pixel(rand_pixel());
            // stray flush mid-frame, nothing owed so it is dropped
            if (with_noise && flush_owed == 0 && $urandom_range(19) == 0) send_flush(1);
        end while (flush_owed == 0);
    endtask

    // hold the source off until every predicted beat has come out
    task automatic pause_until_drained();
        i_in_valid <= 1'b0;
        while (pixels_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        case (idx)
            CFG_FRAME_WIDTH:  cfg_width  = data;
            CFG_FRAME_HEIGHT: cfg_height = data;
            CFG_BORDER_ROWS:  cfg_border = data[BRD_W-1:0];
            CFG_BLUR_ENABLE:  cfg_blur   = data[0];
            CFG_INPUT_FORMAT: cfg_format = data[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int unsigned w, input int unsigned h,
                              input int unsigned bord, input logic blur,
                              input logic fmt);
        pause_until_drained();
        write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
        write_reg(CFG_BORDER_ROWS, CFG_DATA_W'(bord));
        write_reg(CFG_BLUR_ENABLE, CFG_DATA_W'(blur));
        write_reg(CFG_INPUT_FORMAT, CFG_DATA_W'(fmt));
        i_cfg_we <= 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // reset values: 640 wide 5:5:5 input shows up once row 1 starts; then the
    // geometry shrinks in mid-frame and the raster wraps into a 3x3 frame
    task automatic test_reset_defaults();
        set_idling(IDLE_NONE);
        repeat (640 + 3) send_pixel(PIX_W'($urandom()));
        set_config(3, 3, 1, cfg_blur, cfg_format);
        send_frame(1'b0);
        send_flush(flush_owed);
    endtask

    // smallest frame with border 0 acting as 1, so only the center is blurred;
    // opens with a flush while nothing is owed and ends with a surplus flush
    task automatic test_rgb888_blur();
        logic [PIX_W-1:0] pix [9] = '{24'h000000, 24'hffffff, 24'h0f0f0f,
                                      24'hffffff, 24'h808080, 24'hf8f8f8,
                                      24'h070707, 24'hffffff, 24'h123456};
        set_idling(IDLE_NONE);
        set_config(3, 3, 0, 1'b1, FMT_RGB888);
        send_flush(1);
        foreach (pix[k]) send_pixel(pix[k]);
        send_flush(flush_owed + 1);
    endtask

    // 5:5:5 widening with blur off; bits above 14 are junk; the frame is left
    // only partly drained so the next pixel drops the rest
    task automatic test_rgb555_widen();
        logic [PIX_W-1:0] pix [9] = '{24'h007fff, 24'hff8000, 24'h007c00,
                                      24'h0003e0, 24'h00001f, 24'h005555,
                                      24'h002aaa, 24'haa0421, 24'h000000};
        set_idling(IDLE_NONE);
        set_config(3, 3, 1, 1'b0, FMT_RGB555);
        foreach (pix[k]) send_pixel(pix[k]);
        send_flush(2);
    endtask

    // register extremes: width past the line buffer clamps to its size, height
    // below 3 clamps up, and the tallest frame leaves two blurred rows
    task automatic test_config_extremes();
        set_idling(IDLE_SENDER);
        set_config(4095, 0, 1023, 1'b1, FMT_RGB888);
        send_frame(1'b0);
        send_flush(flush_owed);
        set_idling(IDLE_RECEIVER);
        set_config(0, 4095, 1023, 1'b1, FMT_RGB555);
        send_frame(1'b0);
        send_flush(flush_owed);
    endtask

    // mostly small well-formed frames with random geometry and drains; some
    // drains are cut short or overrun, and the source sometimes waits for
    // the output to empty before a frame
    task automatic test_random_frames();
        int unsigned items;
        int unsigned frame_no;
        int unsigned w;
        int unsigned h;
        int unsigned pick;
        items    = 0;
        frame_no = 0;
        while (items < RANDOM_ITEMS) begin
            set_idling(idle_mode_e'(frame_no % 4));
            if (frame_no % 7 == 3) pause_until_drained();
            if (frame_no == 0 || $urandom_range(2) == 0) begin
                if ($urandom_range(9) == 0) w = $urandom_range(2);
                else if ($urandom_range(15) == 0) w = $urandom_range(13, 64);
                else w = $urandom_range(3, 12);
                h = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 9);
                set_config(w, h, ($urandom_range(5) == 0) ? 0 : $urandom_range(1, 4),
                           $urandom_range(3) != 0, $urandom_range(1));
            end
            items += eff_width() * eff_height();
            send_frame(1'b1);
            pick = $urandom_range(99);
            if (pick < 70) begin
                items += flush_owed;
                send_flush(flush_owed);
            end else if (pick < 85) begin
                send_flush($urandom_range(flush_owed - 1));
            end else begin
                items += flush_owed;
                send_flush(flush_owed + $urandom_range(1, 3));
            end
            frame_no++;
        end
        send_flush(flush_owed);
    endtask

    // ---------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------
    initial begin : main_seq
        int k;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_FRAME_WIDTH;
        i_cfg_data = '0;

        // shadow state after reset; line buffer contents never reach a result
        cfg_width  = RST_FRAME_WIDTH;
        cfg_height = RST_FRAME_HEIGHT;
        cfg_border = RST_BORDER_ROWS;
        cfg_blur   = 1'b1;
        cfg_format = FMT_RGB555;
        for (k = 0; k < MAX_W; k++) begin
            above_line[k] = '0;
            mid_line[k]   = '0;
        end
        for (k = 0; k < 9; k++) win[k] = '0;
        col_pos    = 0;
        row_pos    = 0;
        flush_owed = 0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_rgb888_blur();
        test_rgb555_widen();
        test_config_extremes();
        test_random_frames();

        // let the last beats out, then a short quiet tail
        pause_until_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (mismatch_cnt == 0 && pixels_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/rgbblur_pkg.sv
rtl/rgbblur_ram.sv
rtl/rgbblur_seq.sv
rtl/rgbblur_win.sv
rtl/rgbblur_ofifo.sv
rtl/rgb555_expand_and_3x3_blur.sv
tb/tb.sv
